>>> design/vna_pkg.sv
// Package for the vertex normal accumulator: payload structs, command codes,
// widths and the shared helper constants. No dependencies.
package vna_pkg;

  localparam int unsigned VertexCount = 1024;
  localparam int unsigned IdxW        = $clog2(VertexCount);
  localparam int unsigned CoordW      = 16;
  localparam int unsigned AccW        = 24;
  localparam int unsigned PosMemW     = 3 * CoordW;
  localparam int unsigned AccMemW     = 3 * AccW;
  localparam int unsigned QOne        = 16384;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         vertex_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] start_nx;
    logic signed [15:0] start_ny;
    logic signed [15:0] start_nz;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
  } req_t;

  typedef struct packed {
    logic [9:0]         out_index;
    logic signed [15:0] out_nx;
    logic signed [15:0] out_ny;
    logic signed [15:0] out_nz;
    logic               zero_length;
  } rsp_t;

  // Request to and answer from the normalizer.
  typedef struct packed {
    logic               start;
    logic signed [40:0] vx;
    logic signed [40:0] vy;
    logic signed [40:0] vz;
  } norm_req_t;

  typedef struct packed {
    logic               done;
    logic               zero;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } norm_rsp_t;

endpackage

>>> design/vna_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module vna_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> design/vna_norm.sv
// Multi-cycle vector normalizer: scale, sum of squares, square root and three
// divisions, one bit per cycle. Depends on vna_pkg.
module vna_norm
  import vna_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  norm_req_t req_i,
  output norm_rsp_t rsp_o
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHIFT = 7'b0000010,
    S_SQ    = 7'b0000100,
    S_ROOT  = 7'b0001000,
    S_DIVI  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } st_e;

  st_e state_q, state_d;
  logic [40:0] mag_q [3];
  logic [2:0]  neg_q;
  logic [1:0]  comp_q;     // component under square or division
  logic [63:0] sq_q;       // sum of squares and root radicand, later the dividend
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q;      // root and divider remainder
  logic [15:0] quo_q;
  logic [15:0] res_q [3];
  logic        zero_q;

  logic [1:0]  next_comp;
  logic [45:0] div_num;
  logic [31:0] prod_in;
  logic [63:0] prod;

  assign prod_in = mag_q[comp_q][31:0];
  assign prod    = prod_in * prod_in;

  // The first division takes component 0; each later one takes the next.
  always_comb begin
    case (comp_q)
      2'd0:    next_comp = 2'd1;
      2'd1:    next_comp = 2'd2;
      default: next_comp = 2'd0;
    endcase
  end

  // Dividend |c| * 16384 + floor(L / 2) for rounding to nearest.
  assign div_num = {mag_q[next_comp][31:0], 14'd0} + {15'd0, root_q[31:1]};

  // Root by the bit pair method: cnt counts 32 pairs; rem_q holds partial
  // remainder, sq_q the radicand shifting out left.
  logic [65:0] rr_next;
  logic [65:0] rr_sub;
  assign rr_next = {rem_q, sq_q[63:62]};
  assign rr_sub  = rr_next - {32'd0, root_q, 2'b01};

  // Long division: rem_q low bits, dividend bits shifted in from sq_q.
  logic [46:0] dd_next;
  logic [46:0] dd_sub;
  assign dd_next = {rem_q[45:0], sq_q[45]};
  assign dd_sub  = dd_next - {15'd0, root_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req_i.start) state_d = S_SHIFT;
      S_SHIFT: if (mag_q[0][40:30] == '0 && mag_q[1][40:30] == '0 &&
                   mag_q[2][40:30] == '0) state_d = S_SQ;
      S_SQ:    if (comp_q == 2'd2) state_d = S_ROOT;
      S_ROOT:  if (cnt_q == 6'd31) state_d = S_DIVI;
      S_DIVI:  state_d = (root_q == '0) ? S_DONE : S_DIV;
      S_DIV:   if (cnt_q == 6'd45 && comp_q == 2'd2) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        mag_q[0] <= req_i.vx[40] ? 41'(-req_i.vx) : req_i.vx;
        mag_q[1] <= req_i.vy[40] ? 41'(-req_i.vy) : req_i.vy;
        mag_q[2] <= req_i.vz[40] ? 41'(-req_i.vz) : req_i.vz;
        neg_q    <= {req_i.vz[40], req_i.vy[40], req_i.vx[40]};
        comp_q   <= 2'd0;
        sq_q     <= '0;
      end
      S_SHIFT: begin
        if (!(mag_q[0][40:30] == '0 && mag_q[1][40:30] == '0 &&
              mag_q[2][40:30] == '0)) begin
          mag_q[0] <= mag_q[0] >> 1;
          mag_q[1] <= mag_q[1] >> 1;
          mag_q[2] <= mag_q[2] >> 1;
        end
      end
      S_SQ: begin
        sq_q   <= sq_q + prod;
        comp_q <= comp_q + 2'd1;
        cnt_q  <= '0;
        rem_q  <= '0;
        root_q <= '0;
      end
      S_ROOT: begin
        sq_q  <= {sq_q[61:0], 2'b00};
        cnt_q <= cnt_q + 6'd1;
        if (!rr_sub[65]) begin
          rem_q  <= rr_sub[63:0];
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rr_next[63:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      S_DIVI: begin
        comp_q <= 2'd0;
        cnt_q  <= '0;
        rem_q  <= '0;
        sq_q   <= {18'd0, div_num};
        zero_q <= (root_q == '0);
        if (root_q == '0) begin
          res_q[0] <= '0;
          res_q[1] <= '0;
          res_q[2] <= '0;
        end
      end
      S_DIV: begin
        sq_q  <= {sq_q[62:0], 1'b0};
        if (!dd_sub[46]) begin
          rem_q <= {18'd0, dd_sub[45:0]};
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= {18'd0, dd_next[45:0]};
          quo_q <= {quo_q[14:0], 1'b0};
        end
        if (cnt_q == 6'd45) begin
          // Quotient is at most 16384, so 16 bits suffice; clamp anyway.
          res_q[comp_q] <= (({quo_q[14:0], !dd_sub[46]}) > 16'(QOne)) ?
                           16'(QOne) : {quo_q[14:0], !dd_sub[46]};
          comp_q <= comp_q + 2'd1;
          cnt_q  <= '0;
          rem_q  <= '0;
          sq_q   <= {18'd0, div_num};
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_o.done = (state_q == S_DONE);
    rsp_o.zero = zero_q;
    rsp_o.nx   = neg_q[0] ? -res_q[0] : res_q[0];
    rsp_o.ny   = neg_q[1] ? -res_q[1] : res_q[1];
    rsp_o.nz   = neg_q[2] ? -res_q[2] : res_q[2];
  end

`ifndef SYNTHESIS
  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done) else $error("normalizer done held");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && req_i.start) |=> state_q == S_SHIFT)
    else $error("normalizer missed start");
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.done && rsp_o.zero) |-> (res_q[0] == '0 && res_q[1] == '0 && res_q[2] == '0))
    else $error("zero vector gave nonzero normal");
`endif
endmodule

>>> design/vertex_normal_accumulator_top.sv
// Top level of the vertex normal accumulator: sequencer around a position RAM
// and an accumulator RAM, plus the shared normalizer. Depends on vna_pkg,
// vna_ram and vna_norm.
//
// Timing: a load or a no-op leaves the sequencer idle, so the next request can
// follow at once. A read holds it until its result is loaded into the output
// register; the next request can be taken as that result becomes valid. A
// triangle holds it through the position reads, cross products, normalizer and
// three write-backs. The 32-step square root and three 46-step divisions in
// vna_norm set both lengths. Reset clears only control state; the RAMs are not cleared.
module vertex_normal_accumulator_top
  import vna_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PA    = 12'b000000000010, // read position a
    S_PB    = 12'b000000000100, // read position b, latch a
    S_PC    = 12'b000000001000, // read position c, latch b
    S_EDGE  = 12'b000000010000, // form edges from a, b and c
    S_CROSS = 12'b000000100000, // cross products
    S_NORM  = 12'b000001000000, // wait for normalizer
    S_ARD   = 12'b000010000000, // read accumulator of corner k
    S_AWR   = 12'b000100000000, // saturate add and write back
    S_RRD   = 12'b001000000000, // read item: accumulator read
    S_RNORM = 12'b010000000000,
    S_OUT   = 12'b100000000000  // wait for a free output register
  } st_e;

  st_e state_q, state_d;
  req_t req_q;
  logic [1:0] k_q;

  logic signed [15:0] pa_q [3];
  logic signed [15:0] pb_q [3];
  logic signed [16:0] e1_q [3];
  logic signed [16:0] e2_q [3];
  logic signed [33:0] m_q [6];
  logic signed [15:0] nn_q [3];
  logic               rd_zero_q;
  logic               out_valid_q;
  rsp_t               out_q;
  logic               out_load;

  logic              pos_we, acc_we;
  logic [IdxW-1:0]   pos_addr, acc_addr;
  logic [PosMemW-1:0] pos_wdata, pos_rdata;
  logic [AccMemW-1:0] acc_wdata, acc_rdata;
  norm_req_t nreq;
  norm_rsp_t nrsp;

  vna_ram #(.Width(PosMemW), .Depth(VertexCount)) u_pos_ram (
    .clk_i, .we_i(pos_we), .addr_i(pos_addr), .wdata_i(pos_wdata), .rdata_o(pos_rdata)
  );
  vna_ram #(.Width(AccMemW), .Depth(VertexCount)) u_acc_ram (
    .clk_i, .we_i(acc_we), .addr_i(acc_addr), .wdata_i(acc_wdata), .rdata_o(acc_rdata)
  );
  vna_norm u_norm (.clk_i, .rst_ni, .req_i(nreq), .rsp_o(nrsp));

  // The input is taken whenever the sequencer is idle. A finished read holds
  // its normal in nn_q and waits in S_OUT until the output register is free,
  // which stalls the input only while an earlier result is still not taken.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  logic [IdxW-1:0] corner_k;
  always_comb begin
    case (k_q)
      2'd0:    corner_k = req_q.corner_a;
      2'd1:    corner_k = req_q.corner_b;
      default: corner_k = req_q.corner_c;
    endcase
  end

  // Saturating accumulator add, one component at a time.
  function automatic logic [AccW-1:0] sat_add(logic [AccW-1:0] a, logic signed [15:0] b);
    logic signed [AccW:0] s;
    s = $signed({a[AccW-1], a}) + (AccW+1)'(b);
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    return s[AccW-1:0];
  endfunction

  always_comb begin
    pos_we    = 1'b0;
    acc_we    = 1'b0;
    pos_addr  = req_q.corner_a;
    acc_addr  = corner_k;
    pos_wdata = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
    acc_wdata = {AccW'(in_data_i.start_nz), AccW'(in_data_i.start_ny),
                 AccW'(in_data_i.start_nx)};
    nreq.start = 1'b0;
    nreq.vx = 41'(m_q[0] - m_q[1]);
    nreq.vy = 41'(m_q[2] - m_q[3]);
    nreq.vz = 41'(m_q[4] - m_q[5]);
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        unique case (cmd_e'(in_data_i.command))
          CMD_LOAD: begin
            pos_we = 1'b1; acc_we = 1'b1;
            pos_addr = in_data_i.vertex_index;
            acc_addr = in_data_i.vertex_index;
          end
          CMD_TRI:  state_d = S_PA;
          CMD_READ: begin
            acc_addr = in_data_i.vertex_index;
            state_d = S_RRD;
          end
          default: ;
        endcase
      end
      S_PA:    begin pos_addr = req_q.corner_a; state_d = S_PB; end
      S_PB:    begin pos_addr = req_q.corner_b; state_d = S_PC; end
      S_PC:    begin pos_addr = req_q.corner_c; state_d = S_EDGE; end
      S_EDGE:  state_d = S_CROSS;
      S_CROSS: state_d = S_NORM;
      // The cross products are registered by now; the normalizer takes them
      // while idle and ignores the held start once it is running.
      S_NORM: begin
        nreq.start = 1'b1;
        if (nrsp.done) state_d = S_ARD;
      end
      S_ARD:   state_d = S_AWR;
      S_AWR: begin
        acc_we = 1'b1;
        acc_wdata = {sat_add(acc_rdata[3*AccW-1:2*AccW], nn_q[2]),
                     sat_add(acc_rdata[2*AccW-1:AccW],   nn_q[1]),
                     sat_add(acc_rdata[AccW-1:0],        nn_q[0])};
        state_d = (k_q == 2'd2) ? S_IDLE : S_ARD;
      end
      S_RRD: begin
        nreq.start = 1'b1;
        nreq.vx = 41'($signed(acc_rdata[AccW-1:0]));
        nreq.vy = 41'($signed(acc_rdata[2*AccW-1:AccW]));
        nreq.vz = 41'($signed(acc_rdata[3*AccW-1:2*AccW]));
        state_d = S_RNORM;
      end
      S_RNORM: if (nrsp.done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    if (state_q == S_PB) begin
      for (int i = 0; i < 3; i++) pa_q[i] <= pos_rdata[16*i +: 16];
    end
    if (state_q == S_PC) begin
      for (int i = 0; i < 3; i++) pb_q[i] <= pos_rdata[16*i +: 16];
    end
    if (state_q == S_EDGE) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= 17'(pb_q[i]) - 17'(pa_q[i]);
        e2_q[i] <= 17'($signed(pos_rdata[16*i +: 16])) - 17'(pa_q[i]);
      end
    end
    if (state_q == S_CROSS) begin
      m_q[0] <= e1_q[1] * e2_q[2];
      m_q[1] <= e1_q[2] * e2_q[1];
      m_q[2] <= e1_q[2] * e2_q[0];
      m_q[3] <= e1_q[0] * e2_q[2];
      m_q[4] <= e1_q[0] * e2_q[1];
      m_q[5] <= e1_q[1] * e2_q[0];
    end
    if (state_q == S_NORM && nrsp.done) begin
      nn_q[0] <= nrsp.nx; nn_q[1] <= nrsp.ny; nn_q[2] <= nrsp.nz;
      k_q     <= 2'd0;
    end
    if (state_q == S_AWR) begin
      k_q <= k_q + 2'd1;
    end
    if (state_q == S_RNORM && nrsp.done) begin
      nn_q[0]   <= nrsp.nx;
      nn_q[1]   <= nrsp.ny;
      nn_q[2]   <= nrsp.nz;
      rd_zero_q <= nrsp.zero;
    end
    if (out_load) begin
      out_q.out_index   <= req_q.vertex_index;
      out_q.out_nx      <= nn_q[0];
      out_q.out_ny      <= nn_q[1];
      out_q.out_nz      <= nn_q[2];
      out_q.zero_length <= rd_zero_q;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accepted while busy");
  a_out_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT) else $error("stray result");
  a_three_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AWR && k_q == 2'd2) |=> state_q == S_IDLE)
    else $error("triangle write-back order broken");
`endif
endmodule
